FILE: hw/rtl/exp_golomb_bit_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Exp-Golomb bit writer
// ----------------------------------------------------------------------------
`ifndef EXP_GOLOMB_BIT_WRITER_ASSERT_SVH
`define EXP_GOLOMB_BIT_WRITER_ASSERT_SVH

// same-cycle implication
`define EGBW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EGBW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/egbw_pkg.sv
// ----------------------------------------------------------------------------
// egbw_pkg
// Shared types, constants and helpers of the Exp-Golomb bit writer.
// ----------------------------------------------------------------------------
package egbw_pkg;

   localparam int WORD_BITS   = 32;
   localparam int POS_W       = 5;               // bit position inside a word
   localparam int CHUNK_W     = 2 * WORD_BITS;   // longest code of one request
   localparam int LEN_W       = 7;               // 0 .. CHUNK_W - 1
   localparam int WIN_W       = 3 * WORD_BITS;   // pending word plus a chunk
   localparam int QUEUE_DEPTH = 3;

   typedef enum logic [2:0] {
      CMD_FIXED = 3'd0,
      CMD_UE    = 3'd1,
      CMD_SE    = 3'd2,
      CMD_TRAIL = 3'd3,
      CMD_END   = 3'd4
   } cmd_type;

   // code bits left aligned in chunk, len of them valid
   typedef struct packed {
      logic [CHUNK_W-1:0] chunk;
      logic [LEN_W-1:0]   len;
   } code_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] out_word;
      logic [2:0]           valid_bytes;
      logic                 last_word;
      logic [WORD_BITS-1:0] total_bits;
   } rsp_type;

   // number of significant bits of x (position of the top one, plus one)
   function automatic logic [5:0] bit_len(input logic [WORD_BITS-1:0] x);
      logic [5:0] n;
      n = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (x[i]) n = 6'(i + 1);
      end
      return n;
   endfunction

endpackage

FILE: hw/rtl/egbw_req_if.sv
// ----------------------------------------------------------------------------
// egbw_req_if
// Request channel: command, value and fixed field width.
// ----------------------------------------------------------------------------
interface egbw_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [31:0] value;
   logic [5:0]  bit_count;

   modport source (output valid, command, value, bit_count, input ready);
   modport sink   (input valid, command, value, bit_count, output ready);
endinterface

FILE: hw/rtl/egbw_rsp_if.sv
// ----------------------------------------------------------------------------
// egbw_rsp_if
// Result channel: packed words, byte count, last flag and stream length.
// ----------------------------------------------------------------------------
interface egbw_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_word;
   logic [2:0]  valid_bytes;
   logic        last_word;
   logic [31:0] total_bits;

   modport source (output valid, out_word, valid_bytes, last_word, total_bits,
                   input ready);
   modport sink   (input valid, out_word, valid_bytes, last_word, total_bits,
                   output ready);
endinterface

FILE: hw/rtl/exp_golomb_bit_writer.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer
// Packs fixed fields, ue(v)/se(v) codes and RBSP trailing bits MSB first
// into 32-bit words; the end command flushes the partial word.
//
//   channel    role    carries
//   req_chan   sink    command, value, bit_count
//   rsp_chan   source  out_word, valid_bytes, last_word, total_bits
//
// One request per cycle while req_chan.ready is high. A request is registered,
// then coded and packed into the result queue, whose head drives rsp_chan.
// The three-entry result queue drains one word per cycle while rsp_chan.ready
// is high. req_chan.ready drops while a request waits and two or more words
// are queued; with rsp_chan.ready high only two-word requests cause a stall.
// Synchronous active-high reset clears the partial word, counters and queue.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer
   import egbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   egbw_req_if.sink    req_chan,
   egbw_rsp_if.source  rsp_chan
);

   logic                 in_vld_ff, in_vld_in;
   logic [2:0]           in_cmd_ff;
   logic [31:0]          in_val_ff;
   logic [5:0]           in_cnt_ff;

   logic [WORD_BITS-1:0] pend_ff, pend_in;
   logic [POS_W-1:0]     pc_ff, pc_in;
   logic [WORD_BITS-1:0] len_ff, len_in;

   rsp_type              q_ff [QUEUE_DEPTH];
   rsp_type              q_in [QUEUE_DEPTH];
   logic [1:0]           cnt_ff, cnt_in;

   code_type             code;
   logic [WIN_W-1:0]     win;
   logic [LEN_W-1:0]     total;
   logic [WORD_BITS:0]   len_sum;
   logic [5:0]           vb_sum;
   logic                 accept, commit, pop;
   logic [1:0]           cnt_mid, nnew;
   rsp_type              new0, new1;

   egbw_encode u_encode (
      .command   (in_cmd_ff),
      .value     (in_val_ff),
      .bit_count (in_cnt_ff),
      .pend_cnt  (pc_ff),
      .code      (code)
   );

   assign commit         = in_vld_ff && (cnt_ff <= 2'd1);
   assign req_chan.ready = !in_vld_ff || (cnt_ff <= 2'd1);
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_vld_in      = accept ? 1'b1 : (commit ? 1'b0 : in_vld_ff);

   // place the chunk right behind the pending bits
   always_comb begin
      win     = {pend_ff, {CHUNK_W{1'b0}}} | ({code.chunk, {WORD_BITS{1'b0}}} >> pc_ff);
      total   = LEN_W'(pc_ff) + code.len;
      len_sum = {1'b0, len_ff} + (WORD_BITS+1)'(code.len);
      vb_sum  = 6'(pc_ff) + 6'd7;
   end

   always_comb begin
      pend_in = pend_ff;
      pc_in   = pc_ff;
      len_in  = len_ff;
      nnew    = 2'd0;
      new0    = '{out_word: win[WIN_W-1 -: WORD_BITS], valid_bytes: 3'd4,
                  last_word: 1'b0, total_bits: '0};
      new1    = '{out_word: win[WIN_W-WORD_BITS-1 -: WORD_BITS], valid_bytes: 3'd4,
                  last_word: 1'b0, total_bits: '0};
      if (commit) begin
         case (in_cmd_ff)
            CMD_END: begin
               new0    = '{out_word: pend_ff, valid_bytes: vb_sum[5:3],
                           last_word: 1'b1, total_bits: len_ff};
               nnew    = 2'd1;
               pend_in = '0;
               pc_in   = '0;
               len_in  = '0;
            end
            CMD_FIXED, CMD_UE, CMD_SE, CMD_TRAIL: begin
               len_in = len_sum[WORD_BITS] ? '1 : len_sum[WORD_BITS-1:0];
               if (total >= LEN_W'(2 * WORD_BITS)) begin
                  nnew    = 2'd2;
                  pend_in = win[WORD_BITS-1:0];
                  pc_in   = POS_W'(total - LEN_W'(2 * WORD_BITS));
               end else if (total >= LEN_W'(WORD_BITS)) begin
                  nnew    = 2'd1;
                  pend_in = win[WIN_W-WORD_BITS-1 -: WORD_BITS];
                  pc_in   = POS_W'(total - LEN_W'(WORD_BITS));
               end else begin
                  pend_in = win[WIN_W-1 -: WORD_BITS];
                  pc_in   = total[POS_W-1:0];
               end
            end
            default: begin
               // undefined command: drop
            end
         endcase
      end
   end

   // result queue: slot 0 faces the port, pop shifts, new words append
   always_comb begin
      pop     = (cnt_ff != 2'd0) && rsp_chan.ready;
      cnt_mid = cnt_ff - 2'(pop);
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         q_in[k] = q_ff[k];
      end
      if (pop) begin
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            q_in[k] = q_ff[k+1];
         end
      end
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         if ((nnew != 2'd0) && (2'(k) == cnt_mid)) q_in[k] = new0;
         if ((nnew == 2'd2) && (2'(k) == cnt_mid + 2'd1)) q_in[k] = new1;
      end
      cnt_in = cnt_mid + nnew;
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.out_word    = q_ff[0].out_word;
   assign rsp_chan.valid_bytes = q_ff[0].valid_bytes;
   assign rsp_chan.last_word   = q_ff[0].last_word;
   assign rsp_chan.total_bits  = q_ff[0].total_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         pend_ff   <= '0;
         pc_ff     <= '0;
         len_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         in_vld_ff <= in_vld_in;
         pend_ff   <= pend_in;
         pc_ff     <= pc_in;
         len_ff    <= len_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff <= req_chan.command;
         in_val_ff <= req_chan.value;
         in_cnt_ff <= req_chan.bit_count;
      end
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
         q_ff[k] <= q_in[k];
      end
   end

endmodule

FILE: hw/rtl/egbw_encode.sv
// ----------------------------------------------------------------------------
// egbw_encode
// Turns one request into a left-aligned code chunk and its length.
// ----------------------------------------------------------------------------
module egbw_encode
   import egbw_pkg::*;
(
   input  logic [2:0]       command,
   input  logic [31:0]      value,
   input  logic [5:0]       bit_count,
   input  logic [POS_W-1:0] pend_cnt,
   output code_type         code
);

   logic [5:0]           fix_n;
   logic [WORD_BITS-1:0] se_mag;
   logic [WORD_BITS-1:0] se_map;
   logic [WORD_BITS-1:0] ue_src;
   logic [WORD_BITS-1:0] ue_code;
   logic [5:0]           ue_len;
   logic [LEN_W-1:0]     ue_n;
   logic [2:0]           stop_pos;
   logic [2:0]           pad;

   always_comb begin
      fix_n = (bit_count > 6'(WORD_BITS)) ? 6'(WORD_BITS) : bit_count;

      // signed mapping: v > 0 -> 2v-1, v <= 0 -> -2v, saturate past range
      se_mag = WORD_BITS'(-value);
      if (!value[WORD_BITS-1]) begin
         se_map = (value == '0) ? '0 : {value[WORD_BITS-2:0], 1'b0} - 1'b1;
      end else if (se_mag[WORD_BITS-1]) begin
         se_map = {{(WORD_BITS-1){1'b1}}, 1'b0};
      end else begin
         se_map = {se_mag[WORD_BITS-2:0], 1'b0};
      end

      ue_src = (command == CMD_SE) ? se_map : value;
      if (&ue_src) ue_src = {{(WORD_BITS-1){1'b1}}, 1'b0};
      ue_code = ue_src + 1'b1;
      ue_len  = bit_len(ue_code);
      ue_n    = LEN_W'({ue_len, 1'b0} - 7'd1);

      // stop bit lands at pend_cnt; pad zeros to the byte boundary after it
      stop_pos = pend_cnt[2:0] + 3'd1;
      pad      = 3'(~stop_pos + 3'd1);

      code = '0;
      case (command)
         CMD_FIXED: begin
            code.len   = LEN_W'(fix_n);
            code.chunk = {32'b0, value} << (LEN_W'(CHUNK_W) - LEN_W'(fix_n));
         end
         CMD_UE, CMD_SE: begin
            code.len   = ue_n;
            code.chunk = {32'b0, ue_code} << (LEN_W'(CHUNK_W) - ue_n);
         end
         CMD_TRAIL: begin
            code.len   = LEN_W'(pad) + 7'd1;
            code.chunk = {1'b1, {(CHUNK_W-1){1'b0}}};
         end
         default: begin
            code = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/egbw_checker.sv
// ----------------------------------------------------------------------------
// egbw_checker
// Port-level checks on the result channel of the bit writer.
// ----------------------------------------------------------------------------
`include "exp_golomb_bit_writer_assert.svh"

module egbw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] out_word,
   input logic [2:0]  valid_bytes,
   input logic        last_word,
   input logic [31:0] total_bits
);

   `EGBW_ASSERT_NOW(a_full_word, clock, reset, rsp_valid && !last_word, valid_bytes == 3'd4 && total_bits == 32'd0, "full word with bad byte count or length")
   `EGBW_ASSERT_NOW(a_last_word, clock, reset, rsp_valid && last_word, valid_bytes <= 3'd4 && (valid_bytes != 3'd0 || out_word == 32'd0), "bad flush word")
   `EGBW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_word) && $stable(last_word), "stalled result changed")
   `EGBW_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind exp_golomb_bit_writer egbw_checker u_egbw_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .out_word    (rsp_chan.out_word),
   .valid_bytes (rsp_chan.valid_bytes),
   .last_word   (rsp_chan.last_word),
   .total_bits  (rsp_chan.total_bits)
);

FILE: tb/sv/exp_golomb_bit_writer_test.sv
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_test
// Self-checking bench for the Exp-Golomb bit writer. Requests are queued up
// front (directed corner cases, then random streams mostly ending in trailing
// bits and end), driven with random gaps, and predicted on acceptance. Each
// emitted word is compared field by field against the predicted word stream
// while the result side stalls at random.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_test
   import egbw_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLOCK_PERIOD   = 10;
   localparam int          RESET_CYCLES   = 9;
   localparam int          RANDOM_REQS    = 1550;
   localparam int          DRAIN_INTERVAL = 400;
   localparam int          CYCLE_LIMIT    = 1_500_000;
   localparam int          TAIL_CYCLES    = 10;
   localparam int          PRINT_LIMIT    = 40;
   localparam logic [2:0]  CMD_TOP_CODE   = 3'd7;

   typedef struct {
      logic [2:0]  command;
      logic [31:0] value;
      logic [5:0]  bit_count;
      bit          drain_first;   // hold until every expected word is out
   } writer_request;

   logic clock = 1'b0;
   logic reset;

   egbw_req_if req_chan();
   egbw_rsp_if rsp_chan();

   exp_golomb_bit_writer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   writer_request pending_reqs[$];
   rsp_type       expected_words[$];

   // predicted writer state
   logic [31:0] pack_word;
   logic [4:0]  pack_fill;
   logic [31:0] stream_bits;
   int          step_words;

   int unsigned error_count   = 0;
   int unsigned accepted_reqs = 0;
   int unsigned total_reqs    = 0;
   int unsigned taken_words   = 0;
   int unsigned cycle_count   = 0;
   int unsigned req_gap       = 0;
   int unsigned rsp_stall     = 0;
   logic        req_taken     = 1'b0;

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic clear_writer();
      pack_word   = '0;
      pack_fill   = '0;
      stream_bits = '0;
   endtask

   // append n bits of v, MSB first; a filled word becomes an expected result
   task automatic append_field(input logic [31:0] v, input int unsigned n);
      int unsigned room;
      int unsigned over;
      logic [32:0] sum;
      rsp_type     w;
      if (n == 0 || n > WORD_BITS) return;
      if (n < WORD_BITS) v &= (32'd1 << n) - 32'd1;
      sum = {1'b0, stream_bits} + 33'(n);
      stream_bits = sum[32] ? '1 : sum[31:0];
      room = WORD_BITS - pack_fill;
      if (n < room) begin
         pack_word |= v << (room - n);
         pack_fill = 5'(pack_fill + n);
         return;
      end
      over = n - room;
      pack_word |= v >> over;
      if (step_words < 2) begin
         w.out_word    = pack_word;
         w.valid_bytes = 3'd4;
         w.last_word   = 1'b0;
         w.total_bits  = '0;
         expected_words.push_back(w);
         step_words++;
      end
      pack_word = (over == 0) ? '0 : v << (WORD_BITS - over);
      pack_fill = 5'(over);
   endtask

   task automatic emit_exp_golomb(input logic [31:0] v);
      logic [31:0] code;
      logic [31:0] t;
      int unsigned len;
      len = 0;
      if (v == 32'hFFFF_FFFF) v = 32'hFFFF_FFFE;
      code = v + 32'd1;
      for (t = code; t != 0; t >>= 1) len++;
      if (len > 1) append_field('0, len - 1);
      append_field(code, len);
   endtask

   task automatic predict_request(input logic [2:0] command, input logic [31:0] value,
                                  input logic [5:0] bit_count);
      logic [63:0] mapped;
      int unsigned width;
      int unsigned pad;
      rsp_type     w;
      step_words = 0;
      case (command)
         CMD_FIXED: begin
            width = (bit_count > WORD_BITS) ? WORD_BITS : bit_count;
            append_field(value, width);
         end
         CMD_UE: emit_exp_golomb(value);
         CMD_SE: begin
            if (!value[31])
               mapped = (value == 0) ? 64'd0 : {32'd0, value} * 64'd2 - 64'd1;
            else
               mapped = (64'h1_0000_0000 - {32'd0, value}) * 64'd2;
            if (mapped > 64'hFFFF_FFFE) mapped = 64'hFFFF_FFFE;
            emit_exp_golomb(mapped[31:0]);
         end
         CMD_TRAIL: begin
            append_field(32'd1, 1);
            pad = (8 - (pack_fill & 3'h7)) & 3'h7;
            if (pad != 0) append_field('0, pad);
         end
         CMD_END: begin
            w.out_word    = pack_word;
            w.valid_bytes = 3'((pack_fill + 7) >> 3);
            w.last_word   = 1'b1;
            w.total_bits  = stream_bits;
            expected_words.push_back(w);
            clear_writer();
         end
         default: ;  // undefined codes are dropped
      endcase
   endtask

   function automatic int unsigned idle_length(input bit quiet);
      int unsigned r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 15);
         1: return $urandom >> $urandom_range(0, 31);
         2: return -($urandom >> $urandom_range(0, 31));
         3: begin
            case ($urandom_range(0, 4))
               0: return 32'h0000_0000;
               1: return 32'hFFFF_FFFF;
               2: return 32'h8000_0000;
               3: return 32'h7FFF_FFFF;
               default: return 32'hFFFF_FFFE;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic add_request(input logic [2:0] command, input logic [31:0] value,
                              input logic [5:0] bit_count, input bit drain_first);
      writer_request r;
      r.command     = command;
      r.value       = value;
      r.bit_count   = bit_count;
      r.drain_first = drain_first;
      pending_reqs.push_back(r);
   endtask

   task automatic add_undefined();
      add_request(3'($urandom_range(int'(CMD_END) + 1, CMD_TOP_CODE)), $urandom,
                  6'($urandom), 1'b0);
   endtask

   // one syntax element of a random stream; returns 0 for ignored noise
   task automatic add_element(output bit counted);
      int unsigned r;
      r = $urandom_range(0, 99);
      counted = 1'b1;
      if (r < 35)
         add_request(CMD_FIXED, rand_value(),
                     ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 32))
                                                 : 6'($urandom_range(33, 63)), 1'b0);
      else if (r < 60)
         add_request(CMD_UE, rand_value(), 6'($urandom), 1'b0);
      else if (r < 85)
         add_request(CMD_SE, rand_value(), 6'($urandom), 1'b0);
      else if (r < 91)
         add_request(CMD_TRAIL, $urandom, 6'($urandom), 1'b0);
      else if (r < 96) begin
         add_undefined();
         counted = 1'b0;
      end else
         add_request(CMD_END, $urandom, 6'($urandom), 1'b0);
   endtask

   task automatic build_stimulus();
      int unsigned counted_reqs;
      int unsigned next_drain;
      int unsigned n_elems;
      int unsigned r;
      bit          counted;
      counted_reqs = 0;
      next_drain   = 0;

      // directed corners
      add_request(CMD_END,   32'h0,         6'd0,  1'b0);  // end with empty word
      add_request(CMD_FIXED, 32'hFFFF_FFFF, 6'd0,  1'b0);  // zero-width field
      add_request(CMD_FIXED, 32'hFFFF_FFFF, 6'd32, 1'b0);  // full word at once
      add_request(CMD_FIXED, 32'hA5A5_A5A5, 6'd63, 1'b0);  // width clamps to 32
      add_request(CMD_FIXED, 32'hFFFF_FFFF, 6'd5,  1'b0);  // masked to width
      add_request(CMD_UE,    32'h0,         6'd0,  1'b0);
      add_request(CMD_UE,    32'h1,         6'd0,  1'b0);
      add_request(CMD_UE,    32'hFFFF_FFFF, 6'd0,  1'b0);  // saturates
      add_request(CMD_UE,    32'hFFFF_FFFE, 6'd0,  1'b0);
      add_request(CMD_SE,    32'h0,         6'd0,  1'b0);
      add_request(CMD_SE,    32'h1,         6'd0,  1'b0);
      add_request(CMD_SE,    32'hFFFF_FFFF, 6'd0,  1'b0);
      add_request(CMD_SE,    32'h8000_0000, 6'd0,  1'b0);  // saturates
      add_request(CMD_SE,    32'h7FFF_FFFF, 6'd0,  1'b0);
      add_request(CMD_TRAIL, 32'h0,         6'd0,  1'b0);
      add_request(CMD_END,   32'h0,         6'd0,  1'b0);
      add_request(CMD_FIXED, 32'h55,        6'd7,  1'b0);
      add_request(CMD_TRAIL, 32'hFFFF_FFFF, 6'd63, 1'b0);  // stop bit lands aligned
      add_request(CMD_TRAIL, 32'h0,         6'd0,  1'b0);  // stop bit plus seven zeros
      add_request(CMD_FIXED, 32'h3,         6'd3,  1'b0);
      add_undefined();
      add_undefined();
      add_request(CMD_TOP_CODE, 32'hFFFF_FFFF, 6'd63, 1'b0);
      add_request(CMD_END,   32'hFFFF_FFFF, 6'd63, 1'b0);
      add_request(CMD_END,   32'h0,         6'd0,  1'b0);

      // random streams, mostly closed by trailing bits and end
      while (counted_reqs < RANDOM_REQS) begin
         n_elems = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 80)
                                               : $urandom_range(1, 24);
         if (counted_reqs >= next_drain) begin
            add_request(CMD_FIXED, rand_value(), 6'($urandom_range(0, 32)), 1'b1);
            counted_reqs++;
            next_drain += DRAIN_INTERVAL;
         end
         repeat (n_elems) begin
            add_element(counted);
            if (counted) counted_reqs++;
         end
         r = $urandom_range(0, 9);
         if (r < 8) begin
            add_request(CMD_TRAIL, $urandom, 6'($urandom), 1'b0);
            add_request(CMD_END, $urandom, 6'($urandom), 1'b0);
            counted_reqs += 2;
         end else if (r < 9) begin
            add_request(CMD_END, $urandom, 6'($urandom), 1'b0);
            counted_reqs++;
         end
      end
      add_request(CMD_END, 32'h0, 6'd0, 1'b0);
   endtask

   // request driver
   always @(negedge clock) begin
      writer_request head;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (req_gap > 0) begin
            req_chan.valid <= 1'b0;
            req_gap--;
         end else if (pending_reqs.size() != 0 &&
                      !(pending_reqs[0].drain_first && expected_words.size() != 0)) begin
            head = pending_reqs.pop_front();
            req_chan.command   <= head.command;
            req_chan.value     <= head.value;
            req_chan.bit_count <= head.bit_count;
            req_chan.valid     <= 1'b1;
            req_gap = idle_length((accepted_reqs % 256) >= 192);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_stall = idle_length((taken_words % 200) >= 140);
      end
   end

   // monitor: predict on request acceptance, then check accepted words
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= !reset && req_chan.valid && req_chan.ready;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            predict_request(req_chan.command, req_chan.value, req_chan.bit_count);
            accepted_reqs++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            taken_words++;
            if (expected_words.size() == 0) begin
               report_error($sformatf("word %h with no request pending", rsp_chan.out_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_chan.out_word !== want.out_word)
                  report_error($sformatf("word %0d out_word %h, want %h",
                                         taken_words, rsp_chan.out_word, want.out_word));
               if (rsp_chan.valid_bytes !== want.valid_bytes)
                  report_error($sformatf("word %0d valid_bytes %0d, want %0d",
                                         taken_words, rsp_chan.valid_bytes,
                                         want.valid_bytes));
               if (rsp_chan.last_word !== want.last_word)
                  report_error($sformatf("word %0d last_word %b, want %b",
                                         taken_words, rsp_chan.last_word, want.last_word));
               if (rsp_chan.total_bits !== want.total_bits)
                  report_error($sformatf("word %0d total_bits %0d, want %0d",
                                         taken_words, rsp_chan.total_bits,
                                         want.total_bits));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("exp_golomb_bit_writer_test failed");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_FIXED;
      req_chan.value     = '0;
      req_chan.bit_count = '0;
      rsp_chan.ready     = 1'b0;
      clear_writer();
      build_stimulus();
      total_reqs = pending_reqs.size();
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      while (accepted_reqs != total_reqs) @(negedge clock);
      while (expected_words.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("exp_golomb_bit_writer_test passed");
      else
         $display("exp_golomb_bit_writer_test failed");
      $finish;
   end

endmodule

FILE: exp_golomb_bit_writer.f
+incdir+hw/rtl
hw/rtl/egbw_pkg.sv
hw/rtl/egbw_req_if.sv
hw/rtl/egbw_rsp_if.sv
hw/rtl/egbw_encode.sv
hw/rtl/exp_golomb_bit_writer.sv
hw/rtl/egbw_checker.sv
tb/sv/exp_golomb_bit_writer_test.sv
